>>> sv/assert_macros.svh
// assertion macros used by damped_spring_force
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every edge out of reset
`define DSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in this cycle, consequent in the next
`define DSF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/dsf_pkg.sv
// types and constants of the damped spring force pipeline
`timescale 1ns / 1ps
package dsf_pkg;

  localparam int unsigned Lanes     = 3;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned DiffW     = CoordW + 1;
  localparam int unsigned ProdW     = 2 * DiffW;
  localparam int unsigned SqW       = ProdW;
  localparam int unsigned DotW      = ProdW + 2;
  localparam int unsigned DotMagW   = ProdW;
  localparam int unsigned LenW      = SqW / 2;
  localparam int unsigned RemSqW    = LenW + 3;
  localparam int unsigned SqrtSteps = LenW;
  localparam int unsigned CfgW      = 32;
  localparam int unsigned FracW     = 16;
  localparam int unsigned DenW      = 2 * LenW + FracW;
  localparam int unsigned QW        = 32;
  localparam int unsigned DivSteps  = QW;
  localparam int unsigned ChunkW    = 33;
  localparam int unsigned NW        = 98;
  localparam int unsigned NsW       = NW + 2;
  localparam int unsigned NMagW     = 3 * ChunkW;
  localparam int unsigned PpW       = 2 * ChunkW;
  localparam int unsigned TW        = 4 * ChunkW;

  localparam logic [CfgW-1:0] StiffRst = 32'd65536;
  localparam logic [CfgW-1:0] RestRst  = 32'd65536;
  localparam logic [CfgW-1:0] DampRst  = 32'd6554;

  localparam logic [QW-1:0] LimPos = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] LimNeg = 32'h8000_0000;

  typedef enum logic [1:0] {
    CFG_STIFF = 2'd0,
    CFG_REST  = 2'd1,
    CFG_DAMP  = 2'd2
  } cfg_idx_t;

  typedef logic signed [DiffW-1:0] diff_t;

  typedef struct packed {
    logic [CfgW-1:0] k;
    logic [CfgW-1:0] rest;
    logic [CfgW-1:0] c;
  } cfg_t;

  typedef struct packed {
    diff_t [Lanes-1:0]      d;
    logic signed [DotW-1:0] dot;
    logic                   zero;
  } sq_side_t;

  typedef struct packed {
    logic [SqW-1:0]    s;
    logic [RemSqW-1:0] rem;
    logic [LenW-1:0]   root;
    sq_side_t          side;
  } sq_data_t;

  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [QW-1:0]   tl;
    logic [QW-1:0]   q;
    logic            ovf;
    logic            neg;
  } dv_lane_t;

  typedef struct packed {
    dv_lane_t [Lanes-1:0] lane;
    logic [DenW-1:0]      den;
    logic                 zero;
  } dv_data_t;

  typedef struct packed {
    logic [Lanes-1:0][QW-1:0] frc;
    logic                     zero;
    logic                     sat;
  } res_t;

endpackage

>>> sv/dsf_sqrt_cell.sv
// one digit step of the integer square root chain
`timescale 1ns / 1ps
module dsf_sqrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  dsf_pkg::sq_data_t  in_d,
  output logic               out_vld,
  output dsf_pkg::sq_data_t  out_d
);

  logic                           vld_r, vld_nxt;
  dsf_pkg::sq_data_t              d_r, d_nxt;
  logic [dsf_pkg::RemSqW-1:0]     rem2;
  logic [dsf_pkg::RemSqW-1:0]     trial;
  logic                           ge;

  always_comb begin
    // bring down the next two radicand bits
    rem2  = {in_d.rem[dsf_pkg::RemSqW-3:0], in_d.s[dsf_pkg::SqW-1 -: 2]};
    trial = {1'b0, in_d.root, 2'b01};
    ge    = rem2 >= trial;
    d_nxt      = in_d;
    d_nxt.s    = {in_d.s[dsf_pkg::SqW-3:0], 2'b00};
    d_nxt.rem  = ge ? rem2 - trial : rem2;
    d_nxt.root = {in_d.root[dsf_pkg::LenW-2:0], ge};
    vld_nxt    = in_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

>>> sv/dsf_div_cell.sv
// one quotient bit of the restoring divider, all three axes side by side
`timescale 1ns / 1ps
module dsf_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  dsf_pkg::dv_data_t  in_d,
  output logic               out_vld,
  output dsf_pkg::dv_data_t  out_d
);

  logic                       vld_r, vld_nxt;
  dsf_pkg::dv_data_t          d_r, d_nxt;
  logic [dsf_pkg::DenW:0]     rem2 [dsf_pkg::Lanes];
  logic [dsf_pkg::DenW:0]     sub  [dsf_pkg::Lanes];
  logic [dsf_pkg::Lanes-1:0]  ge;

  always_comb begin
    d_nxt = in_d;
    for (int i = 0; i < dsf_pkg::Lanes; i++) begin
      rem2[i] = {in_d.lane[i].rem, in_d.lane[i].tl[dsf_pkg::QW-1]};
      sub[i]  = rem2[i] - {1'b0, in_d.den};
      ge[i]   = rem2[i] >= {1'b0, in_d.den};
      d_nxt.lane[i].rem = ge[i] ? sub[i][dsf_pkg::DenW-1:0] : rem2[i][dsf_pkg::DenW-1:0];
      d_nxt.lane[i].tl  = {in_d.lane[i].tl[dsf_pkg::QW-2:0], 1'b0};
      d_nxt.lane[i].q   = {in_d.lane[i].q[dsf_pkg::QW-2:0], ge[i]};
    end
    vld_nxt = in_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

>>> sv/dsf_force_mac.sv
// multiply and add stages from spring length to dividend and divisor
`timescale 1ns / 1ps
module dsf_force_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [dsf_pkg::LenW-1:0] len,
  input  dsf_pkg::sq_side_t  side,
  input  dsf_pkg::cfg_t      cfg,
  output logic               out_vld,
  output dsf_pkg::dv_data_t  out_d
);

  localparam int unsigned Stages = 9;
  localparam int unsigned L = dsf_pkg::Lanes;
  localparam int unsigned ChunkLo = 0;

  logic [Stages-1:0] vld_r, vld_nxt;

  // stage 1: magnitudes, length squared
  logic [dsf_pkg::LenW-1:0]           p1_len_r, p1_len_nxt;
  logic [L-1:0][dsf_pkg::DiffW-1:0]   p1_dm_r, p1_dm_nxt;
  logic [L-1:0]                       p1_dneg_r, p1_dneg_nxt;
  logic [dsf_pkg::DiffW-1:0]          p1_diffm_r, p1_diffm_nxt;
  logic                               p1_diffneg_r, p1_diffneg_nxt;
  logic [2*dsf_pkg::LenW-1:0]         p1_ll_r, p1_ll_nxt;
  logic [dsf_pkg::DotMagW-1:0]        p1_dotm_r, p1_dotm_nxt;
  logic                               p1_dotneg_r, p1_dotneg_nxt;
  logic                               p1_zero_r, p1_zero_nxt;
  logic [dsf_pkg::DotW-1:0]           dot_abs;
  logic [dsf_pkg::DiffW-1:0]          d_abs [L];

  // stage 2: first products
  logic [dsf_pkg::LenW-1:0]           p2_len_r, p2_len_nxt;
  logic [L-1:0][dsf_pkg::DiffW-1:0]   p2_dm_r, p2_dm_nxt;
  logic [L-1:0]                       p2_dneg_r, p2_dneg_nxt;
  logic                               p2_diffneg_r, p2_diffneg_nxt;
  logic                               p2_dotneg_r, p2_dotneg_nxt;
  logic                               p2_zero_r, p2_zero_nxt;
  logic [64:0]                        p2_mkd_r, p2_mkd_nxt;
  logic [64:0]                        p2_dlo_r, p2_dlo_nxt;
  logic [64:0]                        p2_dhi_r, p2_dhi_nxt;
  logic [dsf_pkg::DenW-1:0]           p2_den_r, p2_den_nxt;

  // stage 3: damping sum, stiffness products
  logic [L-1:0][dsf_pkg::DiffW-1:0]   p3_dm_r, p3_dm_nxt;
  logic [L-1:0]                       p3_dneg_r, p3_dneg_nxt;
  logic                               p3_diffneg_r, p3_diffneg_nxt;
  logic                               p3_dotneg_r, p3_dotneg_nxt;
  logic                               p3_zero_r, p3_zero_nxt;
  logic [dsf_pkg::DenW-1:0]           p3_den_r, p3_den_nxt;
  logic [dsf_pkg::NW-1:0]             p3_cd_r, p3_cd_nxt;
  logic [65:0]                        p3_nlo_r, p3_nlo_nxt;
  logic [64:0]                        p3_nhi_r, p3_nhi_nxt;

  // stage 4: hooke sum, signed damping
  logic [L-1:0][dsf_pkg::DiffW-1:0]   p4_dm_r, p4_dm_nxt;
  logic [L-1:0]                       p4_dneg_r, p4_dneg_nxt;
  logic                               p4_diffneg_r, p4_diffneg_nxt;
  logic                               p4_zero_r, p4_zero_nxt;
  logic [dsf_pkg::DenW-1:0]           p4_den_r, p4_den_nxt;
  logic [dsf_pkg::NW-1:0]             p4_kn_r, p4_kn_nxt;
  logic [dsf_pkg::NsW-1:0]            p4_cds_r, p4_cds_nxt;

  // stage 5: signed numerator
  logic [L-1:0][dsf_pkg::DiffW-1:0]   p5_dm_r, p5_dm_nxt;
  logic [L-1:0]                       p5_dneg_r, p5_dneg_nxt;
  logic                               p5_zero_r, p5_zero_nxt;
  logic [dsf_pkg::DenW-1:0]           p5_den_r, p5_den_nxt;
  logic [dsf_pkg::NsW-1:0]            p5_ns_r, p5_ns_nxt;

  // stage 6: numerator magnitude, result signs
  logic [L-1:0][dsf_pkg::DiffW-1:0]   p6_dm_r, p6_dm_nxt;
  logic [L-1:0]                       p6_neg_r, p6_neg_nxt;
  logic                               p6_zero_r, p6_zero_nxt;
  logic [dsf_pkg::DenW-1:0]           p6_den_r, p6_den_nxt;
  logic [dsf_pkg::NMagW-1:0]          p6_nmag_r, p6_nmag_nxt;
  logic [dsf_pkg::NsW-1:0]            ns_abs;

  // stage 7: partial products of numerator times axis
  logic [L-1:0][2:0][dsf_pkg::PpW-1:0] p7_pp_r, p7_pp_nxt;
  logic [L-1:0]                       p7_neg_r, p7_neg_nxt;
  logic                               p7_zero_r, p7_zero_nxt;
  logic [dsf_pkg::DenW-1:0]           p7_den_r, p7_den_nxt;

  // stage 8: full dividends
  logic [L-1:0][dsf_pkg::TW-1:0]      p8_t_r, p8_t_nxt;
  logic [L-1:0]                       p8_neg_r, p8_neg_nxt;
  logic                               p8_zero_r, p8_zero_nxt;
  logic [dsf_pkg::DenW-1:0]           p8_den_r, p8_den_nxt;

  // stage 9: divider setup and overflow check
  dsf_pkg::dv_data_t                  p9_r, p9_nxt;

  always_comb begin
    vld_nxt = {vld_r[Stages-2:0], in_vld};

    // stage 1
    p1_len_nxt     = len;
    p1_diffneg_nxt = len < {1'b0, cfg.rest};
    p1_diffm_nxt   = p1_diffneg_nxt ? {1'b0, cfg.rest} - len : len - {1'b0, cfg.rest};
    p1_ll_nxt      = len * len;
    p1_dotneg_nxt  = side.dot[dsf_pkg::DotW-1];
    dot_abs        = p1_dotneg_nxt ? -side.dot : side.dot;
    p1_dotm_nxt    = dot_abs[dsf_pkg::DotMagW-1:0];
    p1_zero_nxt    = side.zero;
    for (int i = 0; i < L; i++) begin
      p1_dneg_nxt[i] = side.d[i][dsf_pkg::DiffW-1];
      d_abs[i]       = p1_dneg_nxt[i] ? -side.d[i] : side.d[i];
      p1_dm_nxt[i]   = d_abs[i];
    end

    // stage 2
    p2_len_nxt     = p1_len_r;
    p2_dm_nxt      = p1_dm_r;
    p2_dneg_nxt    = p1_dneg_r;
    p2_diffneg_nxt = p1_diffneg_r;
    p2_dotneg_nxt  = p1_dotneg_r;
    p2_zero_nxt    = p1_zero_r;
    p2_mkd_nxt     = cfg.k * p1_diffm_r;
    p2_dlo_nxt     = p1_dotm_r[ChunkLo +: dsf_pkg::ChunkW] * cfg.c;
    p2_dhi_nxt     = p1_dotm_r[dsf_pkg::DotMagW-1:dsf_pkg::ChunkW] * cfg.c;
    p2_den_nxt     = {p1_ll_r, {dsf_pkg::FracW{1'b0}}};

    // stage 3
    p3_dm_nxt      = p2_dm_r;
    p3_dneg_nxt    = p2_dneg_r;
    p3_diffneg_nxt = p2_diffneg_r;
    p3_dotneg_nxt  = p2_dotneg_r;
    p3_zero_nxt    = p2_zero_r;
    p3_den_nxt     = p2_den_r;
    p3_cd_nxt      = dsf_pkg::NW'(p2_dlo_r) + {p2_dhi_r, {dsf_pkg::ChunkW{1'b0}}};
    p3_nlo_nxt     = p2_mkd_r[dsf_pkg::ChunkW-1:0] * p2_len_r;
    p3_nhi_nxt     = p2_mkd_r[64:dsf_pkg::ChunkW] * p2_len_r;

    // stage 4
    p4_dm_nxt      = p3_dm_r;
    p4_dneg_nxt    = p3_dneg_r;
    p4_diffneg_nxt = p3_diffneg_r;
    p4_zero_nxt    = p3_zero_r;
    p4_den_nxt     = p3_den_r;
    p4_kn_nxt      = dsf_pkg::NW'(p3_nlo_r) + {p3_nhi_r, {dsf_pkg::ChunkW{1'b0}}};
    p4_cds_nxt     = p3_dotneg_r ? -dsf_pkg::NsW'(p3_cd_r) : dsf_pkg::NsW'(p3_cd_r);

    // stage 5
    p5_dm_nxt      = p4_dm_r;
    p5_dneg_nxt    = p4_dneg_r;
    p5_zero_nxt    = p4_zero_r;
    p5_den_nxt     = p4_den_r;
    p5_ns_nxt      = p4_diffneg_r ? p4_cds_r - dsf_pkg::NsW'(p4_kn_r)
                                  : p4_cds_r + dsf_pkg::NsW'(p4_kn_r);

    // stage 6: force points against separation when numerator is positive
    p6_dm_nxt      = p5_dm_r;
    p6_zero_nxt    = p5_zero_r;
    p6_den_nxt     = p5_den_r;
    ns_abs         = p5_ns_r[dsf_pkg::NsW-1] ? -p5_ns_r : p5_ns_r;
    p6_nmag_nxt    = ns_abs[dsf_pkg::NMagW-1:0];
    for (int i = 0; i < L; i++) begin
      p6_neg_nxt[i] = p5_ns_r[dsf_pkg::NsW-1] == p5_dneg_r[i];
    end

    // stage 7
    p7_neg_nxt     = p6_neg_r;
    p7_zero_nxt    = p6_zero_r;
    p7_den_nxt     = p6_den_r;
    for (int i = 0; i < L; i++) begin
      for (int j = 0; j < 3; j++) begin
        p7_pp_nxt[i][j] = p6_nmag_r[dsf_pkg::ChunkW*j +: dsf_pkg::ChunkW] * p6_dm_r[i];
      end
    end

    // stage 8
    p8_neg_nxt     = p7_neg_r;
    p8_zero_nxt    = p7_zero_r;
    p8_den_nxt     = p7_den_r;
    for (int i = 0; i < L; i++) begin
      p8_t_nxt[i] = dsf_pkg::TW'(p7_pp_r[i][0])
                  + dsf_pkg::TW'({p7_pp_r[i][1], {dsf_pkg::ChunkW{1'b0}}})
                  + {p7_pp_r[i][2], {(2*dsf_pkg::ChunkW){1'b0}}};
    end

    // stage 9: quotient of 2^32 or more saturates, so only 32 bits are divided
    p9_nxt.den  = p8_den_r;
    p9_nxt.zero = p8_zero_r;
    for (int i = 0; i < L; i++) begin
      p9_nxt.lane[i].ovf = p8_t_r[i][dsf_pkg::TW-1:dsf_pkg::QW]
                           >= (dsf_pkg::TW - dsf_pkg::QW)'(p8_den_r);
      p9_nxt.lane[i].rem = p8_t_r[i][dsf_pkg::QW +: dsf_pkg::DenW];
      p9_nxt.lane[i].tl  = p8_t_r[i][dsf_pkg::QW-1:0];
      p9_nxt.lane[i].q   = '0;
      p9_nxt.lane[i].neg = p8_neg_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_len_r     <= p1_len_nxt;
      p1_dm_r      <= p1_dm_nxt;
      p1_dneg_r    <= p1_dneg_nxt;
      p1_diffm_r   <= p1_diffm_nxt;
      p1_diffneg_r <= p1_diffneg_nxt;
      p1_ll_r      <= p1_ll_nxt;
      p1_dotm_r    <= p1_dotm_nxt;
      p1_dotneg_r  <= p1_dotneg_nxt;
      p1_zero_r    <= p1_zero_nxt;

      p2_len_r     <= p2_len_nxt;
      p2_dm_r      <= p2_dm_nxt;
      p2_dneg_r    <= p2_dneg_nxt;
      p2_diffneg_r <= p2_diffneg_nxt;
      p2_dotneg_r  <= p2_dotneg_nxt;
      p2_zero_r    <= p2_zero_nxt;
      p2_mkd_r     <= p2_mkd_nxt;
      p2_dlo_r     <= p2_dlo_nxt;
      p2_dhi_r     <= p2_dhi_nxt;
      p2_den_r     <= p2_den_nxt;

      p3_dm_r      <= p3_dm_nxt;
      p3_dneg_r    <= p3_dneg_nxt;
      p3_diffneg_r <= p3_diffneg_nxt;
      p3_dotneg_r  <= p3_dotneg_nxt;
      p3_zero_r    <= p3_zero_nxt;
      p3_den_r     <= p3_den_nxt;
      p3_cd_r      <= p3_cd_nxt;
      p3_nlo_r     <= p3_nlo_nxt;
      p3_nhi_r     <= p3_nhi_nxt;

      p4_dm_r      <= p4_dm_nxt;
      p4_dneg_r    <= p4_dneg_nxt;
      p4_diffneg_r <= p4_diffneg_nxt;
      p4_zero_r    <= p4_zero_nxt;
      p4_den_r     <= p4_den_nxt;
      p4_kn_r      <= p4_kn_nxt;
      p4_cds_r     <= p4_cds_nxt;

      p5_dm_r      <= p5_dm_nxt;
      p5_dneg_r    <= p5_dneg_nxt;
      p5_zero_r    <= p5_zero_nxt;
      p5_den_r     <= p5_den_nxt;
      p5_ns_r      <= p5_ns_nxt;

      p6_dm_r      <= p6_dm_nxt;
      p6_neg_r     <= p6_neg_nxt;
      p6_zero_r    <= p6_zero_nxt;
      p6_den_r     <= p6_den_nxt;
      p6_nmag_r    <= p6_nmag_nxt;

      p7_pp_r      <= p7_pp_nxt;
      p7_neg_r     <= p7_neg_nxt;
      p7_zero_r    <= p7_zero_nxt;
      p7_den_r     <= p7_den_nxt;

      p8_t_r       <= p8_t_nxt;
      p8_neg_r     <= p8_neg_nxt;
      p8_zero_r    <= p8_zero_nxt;
      p8_den_r     <= p8_den_nxt;

      p9_r         <= p9_nxt;
    end
  end

  assign out_vld = vld_r[Stages-1];
  assign out_d   = p9_r;

endmodule

>>> sv/damped_spring_force.sv
// damped spring force between two masses: pipelined sqrt, multiply and divide
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | positions and velocities of both masses
//   out     | output    | out_valid / out_ready | force on first mass, zero_length, saturated
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// one item per cycle while in_ready is high; from accept to out_valid (3 setup stages,
// 33 square root cells, 9 multiply stages, 32 divider cells, 1 output register)
// reset is synchronous and active low; it clears all valid bits and loads the
// register defaults
// the whole pipeline advances together; a skid register behind the output holds
// one item when out_ready is low, and in_ready drops only while it is full
`timescale 1ns / 1ps
`include "assert_macros.svh"
module damped_spring_force (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] in_pos_a_x,
  input  logic signed [31:0] in_pos_a_y,
  input  logic signed [31:0] in_pos_a_z,
  input  logic signed [31:0] in_pos_b_x,
  input  logic signed [31:0] in_pos_b_y,
  input  logic signed [31:0] in_pos_b_z,
  input  logic signed [31:0] in_vel_a_x,
  input  logic signed [31:0] in_vel_a_y,
  input  logic signed [31:0] in_vel_a_z,
  input  logic signed [31:0] in_vel_b_x,
  input  logic signed [31:0] in_vel_b_y,
  input  logic signed [31:0] in_vel_b_z,

  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y,
  output logic signed [31:0] out_force_z,
  output logic        out_zero_length,
  output logic        out_saturated,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned L = dsf_pkg::Lanes;

  logic en;

  // configuration
  dsf_pkg::cfg_t cfg_r, cfg_nxt;

  // setup stages
  logic                                 s1_vld_r, s2_vld_r, s3_vld_r;
  logic [2:0]                           sv_nxt;
  dsf_pkg::diff_t [L-1:0]               s1_d_r, s1_d_nxt;
  dsf_pkg::diff_t [L-1:0]               s1_v_r, s1_v_nxt;
  logic [L-1:0][dsf_pkg::ProdW-1:0]     s2_sq_r, s2_sq_nxt;
  logic [L-1:0][dsf_pkg::ProdW-1:0]     s2_pr_r, s2_pr_nxt;
  dsf_pkg::diff_t [L-1:0]               s2_d_r, s2_d_nxt;
  dsf_pkg::sq_data_t                    s3_r, s3_nxt;
  logic [dsf_pkg::SqW-1:0]              s_sum;
  logic signed [dsf_pkg::DotW-1:0]      dot_sum;
  logic signed [31:0]                   pa [L];
  logic signed [31:0]                   pb [L];
  logic signed [31:0]                   va [L];
  logic signed [31:0]                   vb [L];

  // chains
  logic                                 sq_vld [dsf_pkg::SqrtSteps+1];
  dsf_pkg::sq_data_t                    sq_d   [dsf_pkg::SqrtSteps+1];
  logic                                 dv_vld [dsf_pkg::DivSteps+1];
  dsf_pkg::dv_data_t                    dv_d   [dsf_pkg::DivSteps+1];

  // result and output
  dsf_pkg::res_t                        res;
  logic [dsf_pkg::QW-1:0]               lim  [L];
  logic [dsf_pkg::QW-1:0]               qm   [L];
  logic [L-1:0]                         over;
  logic                                 push;
  dsf_pkg::res_t                        out_r, out_nxt, skid_r, skid_nxt;
  logic                                 out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;

  assign en        = !skid_vld_r;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (dsf_pkg::cfg_idx_t'(cfg_index))
        dsf_pkg::CFG_STIFF: cfg_nxt.k    = cfg_data;
        dsf_pkg::CFG_REST:  cfg_nxt.rest = cfg_data;
        dsf_pkg::CFG_DAMP:  cfg_nxt.c    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.k    <= dsf_pkg::StiffRst;
      cfg_r.rest <= dsf_pkg::RestRst;
      cfg_r.c    <= dsf_pkg::DampRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // setup: separation, products, sums
  always_comb begin
    pa[0] = in_pos_a_x; pa[1] = in_pos_a_y; pa[2] = in_pos_a_z;
    pb[0] = in_pos_b_x; pb[1] = in_pos_b_y; pb[2] = in_pos_b_z;
    va[0] = in_vel_a_x; va[1] = in_vel_a_y; va[2] = in_vel_a_z;
    vb[0] = in_vel_b_x; vb[1] = in_vel_b_y; vb[2] = in_vel_b_z;
    sv_nxt = {s2_vld_r, s1_vld_r, in_valid};
    s_sum   = '0;
    dot_sum = '0;
    for (int i = 0; i < L; i++) begin
      s1_d_nxt[i]  = dsf_pkg::DiffW'(pa[i]) - dsf_pkg::DiffW'(pb[i]);
      s1_v_nxt[i]  = dsf_pkg::DiffW'(va[i]) - dsf_pkg::DiffW'(vb[i]);
      s2_sq_nxt[i] = $signed(s1_d_r[i]) * $signed(s1_d_r[i]);
      s2_pr_nxt[i] = $signed(s1_d_r[i]) * $signed(s1_v_r[i]);
      s_sum   = s_sum + s2_sq_r[i];
      dot_sum = dot_sum + dsf_pkg::DotW'($signed(s2_pr_r[i]));
    end
    s2_d_nxt         = s1_d_r;
    s3_nxt.s         = s_sum;
    s3_nxt.rem       = '0;
    s3_nxt.root      = '0;
    s3_nxt.side.d    = s2_d_r;
    s3_nxt.side.dot  = dot_sum;
    s3_nxt.side.zero = s_sum == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= sv_nxt[0];
      s2_vld_r <= sv_nxt[1];
      s3_vld_r <= sv_nxt[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r  <= s1_d_nxt;
      s1_v_r  <= s1_v_nxt;
      s2_sq_r <= s2_sq_nxt;
      s2_pr_r <= s2_pr_nxt;
      s2_d_r  <= s2_d_nxt;
      s3_r    <= s3_nxt;
    end
  end

  // square root chain
  assign sq_vld[0] = s3_vld_r;
  assign sq_d[0]   = s3_r;

  for (genvar k = 0; k < dsf_pkg::SqrtSteps; k++) begin : g_sqrt
    dsf_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (sq_vld[k]),
      .in_d    (sq_d[k]),
      .out_vld (sq_vld[k+1]),
      .out_d   (sq_d[k+1])
    );
  end

  dsf_force_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld[dsf_pkg::SqrtSteps]),
    .len     (sq_d[dsf_pkg::SqrtSteps].root),
    .side    (sq_d[dsf_pkg::SqrtSteps].side),
    .cfg     (cfg_r),
    .out_vld (dv_vld[0]),
    .out_d   (dv_d[0])
  );

  // divider chain
  for (genvar k = 0; k < dsf_pkg::DivSteps; k++) begin : g_div
    dsf_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (dv_vld[k]),
      .in_d    (dv_d[k]),
      .out_vld (dv_vld[k+1]),
      .out_d   (dv_d[k+1])
    );
  end

  // clip, apply sign, handle coincident masses
  always_comb begin
    res.sat  = 1'b0;
    res.zero = dv_d[dsf_pkg::DivSteps].zero;
    for (int i = 0; i < L; i++) begin
      lim[i]  = dv_d[dsf_pkg::DivSteps].lane[i].neg ? dsf_pkg::LimNeg : dsf_pkg::LimPos;
      over[i] = dv_d[dsf_pkg::DivSteps].lane[i].ovf
             || dv_d[dsf_pkg::DivSteps].lane[i].q > lim[i];
      qm[i]   = over[i] ? lim[i] : dv_d[dsf_pkg::DivSteps].lane[i].q;
      res.frc[i] = dv_d[dsf_pkg::DivSteps].lane[i].neg ? -qm[i] : qm[i];
      res.sat = res.sat | over[i];
    end
    if (res.zero) begin
      res.frc = '0;
      res.sat = 1'b0;
    end
  end

  // output register with skid
  always_comb begin
    push         = en && dv_vld[dsf_pkg::DivSteps];
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (push) begin
      if (!out_vld_r || out_ready) begin
        out_nxt     = res;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = res;
        skid_vld_nxt = 1'b1;
      end
    end else if (out_vld_r && out_ready) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_force_x     = out_r.frc[0];
  assign out_force_y     = out_r.frc[1];
  assign out_force_z     = out_r.frc[2];
  assign out_zero_length = out_r.zero;
  assign out_saturated   = out_r.sat;

  `DSF_ASSERT(a_skid_behind_out, skid_vld_r |-> out_vld_r, "skid full with output empty")
  `DSF_ASSERT(a_skid_fill, $rose(skid_vld_r) |-> $past(out_vld_r && !out_ready), "skid filled while output free")
  `DSF_ASSERT_NXT(a_skid_drain, skid_vld_r && out_ready, !skid_vld_r, "skid did not drain")
  `DSF_ASSERT(a_zero_quiet, out_vld_r && out_r.zero |-> out_r.frc == '0 && !out_r.sat, "coincident item carries force")

endmodule
